// ===== rtl/crla_pkg.sv =====
// crla_pkg: shared types and constants of the CRLF line assembler.
// Used by crla_front, crla_back and crlf_line_assembler; no dependencies.
`default_nettype none

package crla_pkg;

  // Character codes
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Queue sizes
  localparam int unsigned CQ_DEPTH = 4;
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);

  // Command from front to back
  typedef enum logic {
    CMD_DATA,
    CMD_EMIT
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic       cr_first;  // store a held-back CR before the byte
    logic       put_byte;  // store the byte itself
    logic [7:0] data;
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic [7:0] line_char;
    logic       last_char;
    logic       empty_line;
  } res_t;

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned RES_W = $bits(res_t);

endpackage

`default_nettype wire

// ===== rtl/crla_fifo.sv =====
// crla_fifo: small synchronous FIFO with occupancy count.
// Generic; used for the command queue and the result queue. No dependencies.
`default_nettype none

module crla_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire logic [WIDTH-1:0]             data_i,
  output logic                              full_o,
  input  wire logic                         pop_i,
  output logic [WIDTH-1:0]                  data_o,
  output logic                              empty_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign data_o  = store_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and count update, wrapping at DEPTH
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crla_front.sv =====
// crla_front: accepts received bytes, tracks a pending CR and turns each
// byte into a store or line-end command. Depends on crla_pkg.
`default_nettype none

module crla_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            cmd_full_i,
  output logic                 cmd_push_o,
  output crla_pkg::cmd_t       cmd_o
);

  logic cr_pending_q, cr_pending_d;
  logic accept;
  logic is_cr, is_lf;

  assign accept = push_i && !cmd_full_i;
  assign is_cr  = (rx_byte_i == crla_pkg::CHAR_CR);
  assign is_lf  = (rx_byte_i == crla_pkg::CHAR_LF);

  // Classify the beat
  always_comb begin
    cmd_o.op       = crla_pkg::CMD_DATA;
    cmd_o.cr_first = cr_pending_q;
    cmd_o.put_byte = !is_cr;
    cmd_o.data     = rx_byte_i;
    cmd_push_o     = 1'b0;
    cr_pending_d   = cr_pending_q;
    if (accept) begin
      if (cr_pending_q && is_lf) begin
        // CR LF closes the line
        cmd_o.op     = crla_pkg::CMD_EMIT;
        cmd_push_o   = 1'b1;
        cr_pending_d = 1'b0;
      end else if (cr_pending_q) begin
        // lone CR becomes data; a new CR stays held back
        cmd_push_o   = 1'b1;
        cr_pending_d = is_cr;
      end else if (is_cr) begin
        cr_pending_d = 1'b1;
      end else begin
        cmd_push_o   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_pending_q <= 1'b0;
    end else begin
      cr_pending_q <= cr_pending_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crla_back.sv =====
// crla_back: executes commands against the line store, tracks the trimmed
// length and streams a finished line into the result queue.
// Depends on crla_pkg.
`default_nettype none

module crla_back #(
  parameter int unsigned LINE_STORE = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire crla_pkg::cmd_t                cmd_i,
  input  wire logic                          cmd_valid_i,
  output logic                               cmd_pop_o,
  input  wire logic [crla_pkg::OQ_CW-1:0]    res_count_i,
  output logic                               res_push_o,
  output crla_pkg::res_t                     res_o
);

  localparam int unsigned KEEP_MAX = LINE_STORE - 1;
  localparam int unsigned CW       = $clog2(LINE_STORE);
  localparam int unsigned AW       = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;
  localparam int unsigned QW       = crla_pkg::OQ_CW;

  typedef enum logic {
    ST_RUN,
    ST_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] stored_q, stored_d;
  logic [CW-1:0] kept_q, kept_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          cr_done_q, cr_done_d;

  // Line store, read data registered
  logic [7:0]    line_mem [KEEP_MAX];
  logic [7:0]    rd_data_q;
  logic          rd_valid_q, rd_valid_d;
  logic          rd_last_q, rd_last_d;
  logic          rd_empty_q, rd_empty_d;
  logic          rd_en;

  logic          put_en;
  logic [7:0]    put_char;
  logic          room;
  logic          emit_last;

  // Result queue has room for one more beat, counting one in flight
  assign room = (res_count_i + QW'(rd_valid_q)) < QW'(crla_pkg::OQ_DEPTH);
  assign emit_last = ((idx_q + CW'(1)) == kept_q);

  // Command execution
  always_comb begin
    state_d    = state_q;
    stored_d   = stored_q;
    kept_d     = kept_q;
    idx_d      = idx_q;
    cr_done_d  = cr_done_q;
    cmd_pop_o  = 1'b0;
    put_en     = 1'b0;
    put_char   = cmd_i.data;
    rd_en      = 1'b0;
    rd_valid_d = 1'b0;
    rd_last_d  = 1'b0;
    rd_empty_d = 1'b0;
    case (state_q)
      ST_RUN: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            crla_pkg::CMD_DATA: begin
              if (cmd_i.cr_first && !cr_done_q) begin
                put_en   = 1'b1;
                put_char = crla_pkg::CHAR_CR;
                if (cmd_i.put_byte) begin
                  cr_done_d = 1'b1;  // byte goes next cycle
                end else begin
                  cmd_pop_o = 1'b1;
                end
              end else begin
                put_en    = cmd_i.put_byte;
                cr_done_d = 1'b0;
                cmd_pop_o = 1'b1;
              end
            end
            crla_pkg::CMD_EMIT: begin
              if (kept_q == '0) begin
                // nothing left after trimming: single empty beat
                if (room) begin
                  rd_valid_d = 1'b1;
                  rd_last_d  = 1'b1;
                  rd_empty_d = 1'b1;
                  stored_d   = '0;
                  cmd_pop_o  = 1'b1;
                end
              end else begin
                idx_d     = '0;
                state_d   = ST_EMIT;
                cmd_pop_o = 1'b1;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (room) begin
          rd_en      = 1'b1;
          rd_valid_d = 1'b1;
          rd_last_d  = emit_last;
          idx_d      = idx_q + CW'(1);
          if (emit_last) begin
            stored_d = '0;
            kept_d   = '0;
            state_d  = ST_RUN;
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase

    // Store a character while the line has space
    if (put_en && (stored_q < CW'(KEEP_MAX))) begin
      stored_d = stored_q + CW'(1);
      if (put_char != crla_pkg::CHAR_SPACE) begin
        kept_d = stored_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_RUN;
      stored_q   <= '0;
      kept_q     <= '0;
      idx_q      <= '0;
      cr_done_q  <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
      rd_empty_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      stored_q   <= stored_d;
      kept_q     <= kept_d;
      idx_q      <= idx_d;
      cr_done_q  <= cr_done_d;
      rd_valid_q <= rd_valid_d;
      rd_last_q  <= rd_last_d;
      rd_empty_q <= rd_empty_d;
    end
  end

  // Line store write and read ports
  always_ff @(posedge clk_i) begin
    if (put_en && (stored_q < CW'(KEEP_MAX))) begin
      line_mem[stored_q[AW-1:0]] <= put_char;
    end
    if (rd_en) begin
      rd_data_q <= line_mem[idx_q[AW-1:0]];
    end
  end

  // Result beat toward the queue
  assign res_push_o       = rd_valid_q;
  assign res_o.line_char  = rd_empty_q ? 8'h00 : rd_data_q;
  assign res_o.last_char  = rd_last_q;
  assign res_o.empty_line = rd_empty_q;

endmodule

`default_nettype wire

// ===== rtl/crlf_line_assembler.sv =====
// crlf_line_assembler: top level; front classifier, command queue, back
// executor with line store, and result queue. Depends on crla_pkg and all
// crla_* modules.
//
// Usage:
//   Input channel: drive rx_byte_i with push high; the byte is taken at a
//   clock edge where full is low. Bytes flow in one per cycle while full is low.
//   Result channel: while empty is low, line_char_o/last_char_o/
//   empty_line_o show the oldest result; pop takes it.
//   A CR LF pair closes a line: the LF command passes the command queue,
//   the ST_EMIT state, the registered line-store read and the result queue
//   (an empty line skips ST_EMIT); then one character per cycle while pop keeps up.
//   Only the first LINE_STORE-1 characters of a line are kept, trailing
//   spaces are trimmed, and an empty line gives one beat with empty_line_o.
//   Throughput: one byte per cycle while full is low; a lone CR followed by
//   a data byte costs the back end two store writes, and a line end reads
//   each emitted character through the single line-store read port.
//   A 4-entry command queue lets bytes keep arriving during a line drain;
//   full rises only when that queue fills.
//   Reset clears the CR tracking, counts and both queues; the line store
//   itself is not cleared. When pop is held low, the 4-entry result queue
//   fills, the back end stops, and full follows once the command queue fills.
`default_nettype none

module crlf_line_assembler #(
  parameter int unsigned LINE_STORE = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       line_char_o,
  output logic             last_char_o,
  output logic             empty_line_o
);

  crla_pkg::cmd_t                  front_cmd;
  logic                            front_push;
  logic                            cmd_full;
  logic [crla_pkg::CMD_W-1:0]      cmd_raw;
  crla_pkg::cmd_t                  back_cmd;
  logic                            cmd_empty;
  logic                            cmd_pop;
  logic [$clog2(crla_pkg::CQ_DEPTH+1)-1:0] cmd_count;

  crla_pkg::res_t                  back_res;
  logic                            res_push;
  logic                            res_full;
  logic [crla_pkg::RES_W-1:0]      res_raw;
  crla_pkg::res_t                  out_res;
  logic [crla_pkg::OQ_CW-1:0]      res_count;

  assign full = cmd_full;

  // Front: byte classification
  crla_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .rx_byte_i  (rx_byte_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (front_push),
    .cmd_o      (front_cmd)
  );

  // Command queue
  crla_fifo #(
    .WIDTH (crla_pkg::CMD_W),
    .DEPTH (crla_pkg::CQ_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_raw),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  assign back_cmd = crla_pkg::cmd_t'(cmd_raw);

  // Back: line store and drain
  crla_back #(
    .LINE_STORE (LINE_STORE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // Result queue
  crla_fifo #(
    .WIDTH (crla_pkg::RES_W),
    .DEPTH (crla_pkg::OQ_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_raw),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign out_res      = crla_pkg::res_t'(res_raw);
  assign line_char_o  = out_res.line_char;
  assign last_char_o  = out_res.last_char;
  assign empty_line_o = out_res.empty_line;

  // Back end never writes a beat the result queue cannot hold
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result queue overflow");

  // Front never pushes a command into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) front_push |-> !cmd_full)
    else $error("command queue overflow");

  // Back end only pops an available command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> (!cmd_empty && (cmd_count != '0)))
    else $error("command pop from empty queue");

  // An empty-line beat is always the last beat and carries a zero character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && empty_line_o) |-> (last_char_o && (line_char_o == 8'h00)))
    else $error("malformed empty-line beat");

endmodule

`default_nettype wire
